FILE: hdl/ptfd_pkg.sv
// ptfd_pkg: shared types and constants for the PID controller with
// trapezoidal integral and filtered derivative.
// No dependencies; used by every module under hdl/.
package ptfd_pkg;

	localparam int DECAY_FRAC = 14;
	localparam int PWM_TOP    = 255;
	localparam int NUM_REGS   = 8;
	localparam int REG_IDX_W  = $clog2(NUM_REGS);
	localparam int REG_DATA_W = 32;

	localparam logic [7:0]         DUTY_MAX        = 8'hFF;
	localparam logic signed [14:0] DECAY_RESET     = 15'sd14564;
	localparam logic signed [31:0] INTEG_MAX_RESET = 32'sd1044480;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_REFERENCE   = 3'd0,
		REG_KP_GAIN     = 3'd1,
		REG_KI_COEF     = 3'd2,
		REG_KD_COEF     = 3'd3,
		REG_DERIV_DECAY = 3'd4,
		REG_INTEG_MAX   = 3'd5,
		REG_INTEG_MIN   = 3'd6,
		REG_INVERT_OUT  = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [7:0]         reference;
		logic signed [15:0] kp_gain;
		logic signed [15:0] ki_coef;
		logic signed [15:0] kd_coef;
		logic signed [14:0] deriv_decay;
		logic signed [31:0] integ_max;
		logic signed [31:0] integ_min;
		logic               invert_out;
	} cfg_t;

	typedef struct packed {
		logic [7:0] duty;
		logic       saturated;
	} result_t;

endpackage

FILE: hdl/ptfd_cfg.sv
// ptfd_cfg: configuration register file, write-only, reset to defaults.
// Depends on ptfd_pkg.
module ptfd_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [ptfd_pkg::REG_IDX_W-1:0]       wr_index,
	input  logic [ptfd_pkg::REG_DATA_W-1:0]      wr_data,
	output ptfd_pkg::cfg_t                       cfg
);

	ptfd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reference   <= '0;
			cfg_q.kp_gain     <= '0;
			cfg_q.ki_coef     <= '0;
			cfg_q.kd_coef     <= '0;
			cfg_q.deriv_decay <= ptfd_pkg::DECAY_RESET;
			cfg_q.integ_max   <= ptfd_pkg::INTEG_MAX_RESET;
			cfg_q.integ_min   <= '0;
			cfg_q.invert_out  <= 1'b0;
		end else if (wr_en) begin
			unique case (ptfd_pkg::reg_index_t'(wr_index))
				ptfd_pkg::REG_REFERENCE:   cfg_q.reference   <= wr_data[7:0];
				ptfd_pkg::REG_KP_GAIN:     cfg_q.kp_gain     <= $signed(wr_data[15:0]);
				ptfd_pkg::REG_KI_COEF:     cfg_q.ki_coef     <= $signed(wr_data[15:0]);
				ptfd_pkg::REG_KD_COEF:     cfg_q.kd_coef     <= $signed(wr_data[15:0]);
				ptfd_pkg::REG_DERIV_DECAY: cfg_q.deriv_decay <= $signed(wr_data[14:0]);
				ptfd_pkg::REG_INTEG_MAX:   cfg_q.integ_max   <= $signed(wr_data[31:0]);
				ptfd_pkg::REG_INTEG_MIN:   cfg_q.integ_min   <= $signed(wr_data[31:0]);
				ptfd_pkg::REG_INVERT_OUT:  cfg_q.invert_out  <= wr_data[0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/ptfd_core.sv
// ptfd_core: single-pass PID arithmetic and the controller state
// (previous error, integral and derivative accumulators). Depends on ptfd_pkg.
module ptfd_core #(
	parameter int FRAC_BITS = 12,
	parameter int ACC_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          sample_s1,
	input  ptfd_pkg::cfg_t      cfg,
	output ptfd_pkg::result_t   result
);

	localparam int LW = ((ACC_WIDTH > 32) ? ACC_WIDTH : 32) + 17;
	localparam int PW = ACC_WIDTH + 15;
	localparam logic signed [LW-1:0] RND = LW'(1) << (ptfd_pkg::DECAY_FRAC - 1);
	localparam logic signed [LW-1:0] TOP = LW'(ptfd_pkg::PWM_TOP) << FRAC_BITS;

	logic signed [8:0]           prev_error_q;
	logic signed [ACC_WIDTH-1:0] integ_acc_q;
	logic signed [ACC_WIDTH-1:0] deriv_acc_q;

	logic signed [8:0]           err;
	logic signed [9:0]           err_sum;
	logic signed [9:0]           err_diff;
	logic signed [24:0]          p_term;
	logic signed [25:0]          i_step;
	logic signed [25:0]          d_step;
	logic signed [LW-1:0]        integ_raw;
	logic signed [LW-1:0]        integ_clamp;
	logic signed [ACC_WIDTH-1:0] integ_next;
	logic signed [PW-1:0]        decay_prod;
	logic signed [LW-1:0]        decay_rnd;
	logic signed [LW-1:0]        deriv_raw;
	logic signed [ACC_WIDTH-1:0] deriv_next;
	logic signed [LW-1:0]        sum;
	logic [7:0]                  duty_raw;

	function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [LW-1:0] x);
		logic signed [LW-1:0] hi;
		logic signed [LW-1:0] lo;
		hi = LW'({1'b0, {(ACC_WIDTH-1){1'b1}}});
		lo = -hi - LW'(1);
		if (x > hi)
			sat_acc = ACC_WIDTH'(hi);
		else if (x < lo)
			sat_acc = ACC_WIDTH'(lo);
		else
			sat_acc = ACC_WIDTH'(x);
	endfunction

	always_comb begin
		err      = $signed({1'b0, cfg.reference}) - $signed({1'b0, sample_s1});
		err_sum  = 10'(err) + 10'(prev_error_q);
		err_diff = 10'(err) - 10'(prev_error_q);
		p_term   = 25'($signed(cfg.kp_gain)) * 25'(err);
		i_step   = 26'($signed(cfg.ki_coef)) * 26'(err_sum);
		d_step   = 26'($signed(cfg.kd_coef)) * 26'(err_diff);

		integ_raw = LW'(integ_acc_q) + LW'(i_step);
		priority if (integ_raw > LW'($signed(cfg.integ_max)))
			integ_clamp = LW'($signed(cfg.integ_max));
		else if (integ_raw < LW'($signed(cfg.integ_min)))
			integ_clamp = LW'($signed(cfg.integ_min));
		else
			integ_clamp = integ_raw;
		integ_next = sat_acc(integ_clamp);

		// decay term rounds to nearest, ties up
		decay_prod = PW'($signed(cfg.deriv_decay)) * PW'(deriv_acc_q);
		decay_rnd  = (LW'(decay_prod) + RND) >>> ptfd_pkg::DECAY_FRAC;
		deriv_raw  = LW'(d_step) + decay_rnd;
		deriv_next = sat_acc(deriv_raw);

		sum = LW'(p_term) + LW'(integ_next) + LW'(deriv_next);
		priority if (sum > TOP) begin
			duty_raw         = ptfd_pkg::DUTY_MAX;
			result.saturated = 1'b1;
		end else if (sum < LW'(0)) begin
			duty_raw         = '0;
			result.saturated = 1'b1;
		end else begin
			duty_raw         = sum[FRAC_BITS +: 8];
			result.saturated = 1'b0;
		end
		result.duty = cfg.invert_out ? (ptfd_pkg::DUTY_MAX - duty_raw) : duty_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			integ_acc_q  <= '0;
			deriv_acc_q  <= '0;
		end else if (step) begin
			prev_error_q <= err;
			integ_acc_q  <= integ_next;
			deriv_acc_q  <= deriv_next;
		end
	end

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(integ_acc_q) && $stable(deriv_acc_q) && $stable(prev_error_q))
		else $error("controller state changed without a step");

	a_err_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> prev_error_q == $past(err))
		else $error("previous error not taken from last step");

endmodule

FILE: hdl/pid_trapezoid_filtered_derivative.sv
// pid_trapezoid_filtered_derivative: top level of the PID controller.
// Depends on ptfd_pkg, ptfd_cfg and ptfd_core.
//
// Usage:
//   Input channel (in_valid/in_ready/sample) carries one ADC word per tick.
//   Output channel (out_valid/out_ready/duty/out_saturated) returns one
//   word per input word, in order.
//   Configuration is written through wr_en/wr_index/wr_data while idle;
//   index order: reference, kp_gain, ki_coef, kd_coef, deriv_decay,
//   integ_max, integ_min, invert_out.
// Path: input register, then result register; out_valid rises when the
//   word moves from the input register into the result register.
// Throughput: one word per cycle while the output is not stalled, set by the
//   state update of the integral and derivative accumulators on each advance.
// Reset: arst_n clears the pipeline, the controller state and loads the
//   register defaults.
// Stall: a held output keeps its word; the input stage stays full and
//   in_ready drops only when both stages are occupied and the output is stalled.
module pid_trapezoid_filtered_derivative #(
	parameter int FRAC_BITS = 12,
	parameter int ACC_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [ptfd_pkg::REG_IDX_W-1:0]       wr_index,
	input  logic [ptfd_pkg::REG_DATA_W-1:0]      wr_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [7:0]                           duty,
	output logic                                 out_saturated
);

	ptfd_pkg::cfg_t    cfg;
	ptfd_pkg::result_t result;
	ptfd_pkg::result_t res_s2;

	logic       valid_s1;
	logic [7:0] sample_s1;
	logic       valid_s2;
	logic       advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	ptfd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	ptfd_core #(
		.FRAC_BITS (FRAC_BITS),
		.ACC_WIDTH (ACC_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.sample_s1 (sample_s1),
		.cfg       (cfg),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			sample_s1 <= sample;
		if (advance)
			res_s2 <= result;
	end

	assign out_valid     = valid_s2;
	assign duty          = res_s2.duty;
	assign out_saturated = res_s2.saturated;

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result register not loaded on advance");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted word lost at input stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(sample_s1))
		else $error("input stage changed while stalled");

endmodule

FILE: test/testbench.sv
// Testbench for pid_trapezoid_filtered_derivative: directed and random ADC words
// checked against an in-bench fixed point PID predictor by a small scoreboard class.
// Depends on ptfd_pkg and the RTL under hdl/.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS   = 12;
	localparam int ACC_WIDTH   = 32;
	localparam int ITEMS       = 800;
	localparam int HOLD_CYCLES = 80;
	localparam int LIMIT       = 300000;

	typedef enum int {PH_WILD, PH_TRACK, PH_RING} phase_kind_t;

	class duty_checker;
		logic [7:0]                  setpoint;
		logic signed [15:0]          kp, ki, kd;
		logic signed [14:0]          decay;
		logic signed [31:0]          integ_hi, integ_lo;
		logic                        invert;
		logic signed [8:0]           last_err;
		logic signed [ACC_WIDTH-1:0] integ_acc, deriv_acc;
		ptfd_pkg::result_t           duty_expected[$];
		int                          mismatches;

		function new();
			setpoint   = 8'd0;
			kp         = 16'sd0;
			ki         = 16'sd0;
			kd         = 16'sd0;
			decay      = ptfd_pkg::DECAY_RESET;
			integ_hi   = ptfd_pkg::INTEG_MAX_RESET;
			integ_lo   = 32'sd0;
			invert     = 1'b0;
			last_err   = 9'sd0;
			integ_acc  = '0;
			deriv_acc  = '0;
			mismatches = 0;
		endfunction

		function void write_reg(ptfd_pkg::reg_index_t idx, logic [31:0] v);
			case (idx)
				ptfd_pkg::REG_REFERENCE:   setpoint = v[7:0];
				ptfd_pkg::REG_KP_GAIN:     kp = v[15:0];
				ptfd_pkg::REG_KI_COEF:     ki = v[15:0];
				ptfd_pkg::REG_KD_COEF:     kd = v[15:0];
				ptfd_pkg::REG_DERIV_DECAY: decay = v[14:0];
				ptfd_pkg::REG_INTEG_MAX:   integ_hi = v;
				ptfd_pkg::REG_INTEG_MIN:   integ_lo = v;
				ptfd_pkg::REG_INVERT_OUT:  invert = v[0];
				default: ;
			endcase
		endfunction

		function longint clamp_acc(longint x);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
			lo = -hi - 1;
			if (x > hi)
				return hi;
			if (x < lo)
				return lo;
			return x;
		endfunction

		function void take_sample(logic [7:0] s);
			longint            err, prop, integ, deriv, total, top, duty_val;
			ptfd_pkg::result_t r;
			err   = longint'(setpoint) - longint'(s);
			prop  = longint'(kp) * err;
			integ = longint'(integ_acc) + longint'(ki) * (err + longint'(last_err));
			if (integ > longint'(integ_hi))
				integ = longint'(integ_hi);
			else if (integ < longint'(integ_lo))
				integ = longint'(integ_lo);
			integ = clamp_acc(integ);
			// decay product rounds to nearest, ties toward +inf
			deriv = longint'(kd) * (err - longint'(last_err))
				+ ((longint'(decay) * longint'(deriv_acc)
				+ (longint'(1) <<< (ptfd_pkg::DECAY_FRAC - 1))) >>> ptfd_pkg::DECAY_FRAC);
			deriv = clamp_acc(deriv);
			total = prop + integ + deriv;
			top   = longint'(ptfd_pkg::PWM_TOP) <<< FRAC_BITS;
			if (total > top) begin
				total = top;
				r.saturated = 1'b1;
			end else if (total < 0) begin
				total = 0;
				r.saturated = 1'b1;
			end else begin
				r.saturated = 1'b0;
			end
			duty_val = total >>> FRAC_BITS;
			if (duty_val > ptfd_pkg::PWM_TOP)
				duty_val = ptfd_pkg::PWM_TOP;
			if (invert)
				duty_val = ptfd_pkg::PWM_TOP - duty_val;
			r.duty = duty_val[7:0];
			duty_expected.push_back(r);
			deriv_acc = deriv[ACC_WIDTH-1:0];
			integ_acc = integ[ACC_WIDTH-1:0];
			last_err  = err[8:0];
		endfunction

		function void check_word(logic [7:0] d, logic s);
			ptfd_pkg::result_t want;
			if (duty_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output word: duty %0d sat %0d", d, s);
				return;
			end
			want = duty_expected.pop_front();
			if (d !== want.duty || s !== want.saturated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("duty word differs: expected %0d/%0d, got %0d/%0d",
						want.duty, want.saturated, d, s);
			end
		endfunction

		function int pending();
			return duty_expected.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	ptfd_pkg::reg_index_t wr_index;
	logic [31:0]          wr_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           sample;
	logic                 out_valid;
	logic                 out_ready;
	logic [7:0]           duty;
	logic                 out_saturated;

	duty_checker board;
	bit          tx_idling;
	bit          rx_idling;
	bit          hold_req;
	int          cycles;

	pid_trapezoid_filtered_derivative #(
		.FRAC_BITS(FRAC_BITS),
		.ACC_WIDTH(ACC_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.duty(duty),
		.out_saturated(out_saturated)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// output side: random stalls, plus one long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_word(duty, out_saturated);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (rx_idling && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(0, 6);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input ptfd_pkg::reg_index_t idx, input logic [31:0] v);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= v;
		@(posedge clk);
		board.write_reg(idx, v);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all(input logic [7:0] sp, input logic [31:0] kp_v, input logic [31:0] ki_v,
		input logic [31:0] kd_v, input logic [31:0] dc_v, input logic [31:0] hi_v,
		input logic [31:0] lo_v, input logic inv_v);
		write_reg(ptfd_pkg::REG_REFERENCE, {24'd0, sp});
		write_reg(ptfd_pkg::REG_KP_GAIN, kp_v);
		write_reg(ptfd_pkg::REG_KI_COEF, ki_v);
		write_reg(ptfd_pkg::REG_KD_COEF, kd_v);
		write_reg(ptfd_pkg::REG_DERIV_DECAY, dc_v);
		write_reg(ptfd_pkg::REG_INTEG_MAX, hi_v);
		write_reg(ptfd_pkg::REG_INTEG_MIN, lo_v);
		write_reg(ptfd_pkg::REG_INVERT_OUT, {31'd0, inv_v});
	endtask

	task automatic send_word(input logic [7:0] s);
		if (tx_idling && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do begin
			@(posedge clk);
		end while (!in_ready);
		board.take_sample(s);
	endtask

	// sender stops and waits for every outstanding word
	task automatic finish_phase();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick16();
		case ($urandom_range(0, 5))
			0: return 32'hFFFF_8000;
			1: return 32'h0000_7FFF;
			2: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick15();
		case ($urandom_range(0, 5))
			0: return 32'hFFFF_C000;
			1: return 32'h0000_3FFF;
			2: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(input phase_kind_t kind, input int count, input bit long_hold);
		logic [7:0] sp;
		logic [7:0] s;
		int         v;
		int         kd_i;
		sp = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
			: 8'($urandom_range(0, 255));
		case (kind)
			PH_WILD:
				set_all(sp, pick16(), pick16(), pick16(), pick15(), pick32(), pick32(),
					1'($urandom_range(0, 1)));
			PH_TRACK: begin
				kd_i = $urandom_range(0, 24000) - 12000;
				set_all(sp, 32'($urandom_range(0, 16384)), 32'($urandom_range(0, 600)),
					32'(kd_i), 32'($urandom_range(8000, 16383)),
					32'($urandom_range(100, 255)) << FRAC_BITS,
					-(32'($urandom_range(0, 50)) << FRAC_BITS), 1'($urandom_range(0, 1)));
			end
			default:
				// decay of -1 with alternating error grows the derivative into saturation
				set_all(8'd128, 32'd0, 32'd0,
					$urandom_range(0, 1) ? 32'h0000_7FFF : 32'hFFFF_8000,
					32'hFFFF_C000, 32'd0, 32'd0, 1'($urandom_range(0, 1)));
		endcase
		if (long_hold)
			hold_req = 1'b1;
		for (int i = 0; i < count; i++) begin
			case (kind)
				PH_TRACK: begin
					v = int'(sp) + $urandom_range(0, 60) - 30;
					if ($urandom_range(0, 15) == 0)
						v = $urandom_range(0, 255);
					s = v < 0 ? 8'd0 : (v > 255 ? 8'd255 : 8'(v));
				end
				PH_RING:
					s = $urandom_range(0, 19) == 0 ? 8'($urandom) : ((i % 2) ? 8'd255 : 8'd0);
				default:
					s = 8'($urandom);
			endcase
			send_word(s);
		end
		finish_phase();
	endtask

	initial begin
		int          random_items;
		int          phase;
		int          count;
		phase_kind_t kind;
		arst_n    = 1'b0;
		wr_en     = 1'b0;
		wr_index  = ptfd_pkg::REG_REFERENCE;
		wr_data   = 32'd0;
		in_valid  = 1'b0;
		sample    = 8'd0;
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		hold_req  = 1'b0;
		board     = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults
		send_word(8'd0);
		send_word(8'd255);
		finish_phase();

		// unit proportional gain, clamp at zero and in-range outputs
		set_all(8'd128, 32'd4096, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		send_word(8'd0);
		send_word(8'd255);
		send_word(8'd128);
		finish_phase();

		// full-scale gain with inverted output
		set_all(8'd255, 32'h0000_7FFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
		send_word(8'd0);
		send_word(8'd255);
		finish_phase();

		// crossed integral limits: max below min
		set_all(8'd200, 32'd0, 32'd1000, 32'd0, 32'd0, 32'd409600, 32'd819200, 1'b0);
		send_word(8'd0);
		send_word(8'd0);
		send_word(8'd0);
		finish_phase();

		// widest integral limits, most negative ki
		set_all(8'd0, 32'd0, 32'hFFFF_8000, 32'd0, 32'h0000_3FFF, 32'h7FFF_FFFF,
			32'h8000_0000, 1'b0);
		send_word(8'd255);
		send_word(8'd255);
		finish_phase();

		// half decay on odd accumulator hits the rounding tie; integral pinned at 100.0
		set_all(8'd0, 32'd0, 32'd0, 32'd1, 32'd8192, 32'd409600, 32'd409600, 1'b0);
		send_word(8'd0);
		send_word(8'd1);
		send_word(8'd1);
		send_word(8'd0);
		send_word(8'd0);
		send_word(8'd255);
		finish_phase();

		// most negative kd and decay
		set_all(8'd0, 32'd0, 32'd0, 32'hFFFF_8000, 32'hFFFF_C000, 32'd0, 32'd0, 1'b0);
		send_word(8'd255);
		send_word(8'd0);
		finish_phase();

		random_items = 0;
		phase = 0;
		while (random_items < ITEMS) begin
			if (phase == 4)
				kind = PH_RING;
			else begin
				case ($urandom_range(0, 9))
					0:       kind = PH_RING;
					1, 2, 3: kind = PH_WILD;
					default: kind = PH_TRACK;
				endcase
			end
			count = (kind == PH_RING) ? 300 : $urandom_range(20, 80);
			if (random_items >= ITEMS - 100) begin
				tx_idling = 1'b0;
				rx_idling = 1'b0;
			end else begin
				tx_idling = $urandom_range(0, 3) != 0;
				rx_idling = $urandom_range(0, 3) != 0;
			end
			if (phase == 2)
				tx_idling = 1'b0;
			run_phase(kind, count, phase == 2);
			random_items += count;
			phase++;
		end

		finish_phase();
		repeat (4) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
